FILE: rtl/sorted_key_table_assert.svh
// Assertion macros shared by the sorted key table RTL.
// Expects signals named clock and reset in the including module.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define SKT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SKT_ASSERT_IMPL(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

`else

`define SKT_ASSERT(name, prop, msg)
`define SKT_ASSERT_IMPL(name, pre, post, msg)

`endif

`endif

FILE: rtl/skt_pkg.sv
// Types, codes and constants of the sorted key table.
// No dependencies; used by skt_cell and sorted_key_table.
`default_nettype none

package skt_pkg;

   localparam int CAPACITY_DEFAULT = 8;
   localparam int KEY_W            = 32;
   localparam int VALUE_W          = 32;
   localparam int INDEX_W          = 6;
   localparam int COUNT_W          = 7;
   localparam int STATUS_W         = 3;
   localparam int OP_W             = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
   localparam logic [OP_W-1:0] OP_DUMP   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUP     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic signed [KEY_W-1:0]   key;
      logic [VALUE_W-1:0]        value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [INDEX_W-1:0]        index;
      logic signed [KEY_W-1:0]   key_out;
      logic [VALUE_W-1:0]        value_out;
      logic [COUNT_W-1:0]        entry_count;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic signed [KEY_W-1:0]   key;
      logic [VALUE_W-1:0]        value;
   } entry_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_DELETE,
      CMD_ROTATE
   } cell_cmd_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      cell_cmd_type              cmd;
      entry_type                 req;
      entry_type                 head;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DUMP
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/skt_cell.sv
// One cell of the sorted chain: holds one entry, compares it with the
// request key and takes its neighbor's entry on shifts. Uses skt_pkg.
`default_nettype none

module skt_cell (
   input  wire logic                  clock,
   input  wire skt_pkg::cell_ctrl_type ctrl,
   input  wire logic                  occ_self,
   input  wire logic                  occ_next,
   input  wire logic                  left_lt,
   input  wire skt_pkg::entry_type    left_entry,
   input  wire skt_pkg::entry_type    right_entry,
   output skt_pkg::entry_type         entry,
   output logic                       lt,
   output logic                       eq
);
   import skt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   assign lt    = occ_self && (entry_ff.key < ctrl.req.key);
   assign eq    = occ_self && (entry_ff.key == ctrl.req.key);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.cmd)
         CMD_INSERT: begin
            // first cell at or above the key takes the new word, the rest move up
            if (!lt) begin
               if (left_lt) begin
                  entry_in = ctrl.req;
               end else begin
                  entry_in = left_entry;
               end
            end
         end
         CMD_DELETE: begin
            if (!lt) begin
               entry_in = right_entry;
            end
         end
         CMD_ROTATE: begin
            // advance toward the head; the last occupied cell wraps the head around
            if (occ_next) begin
               entry_in = right_entry;
            end else if (occ_self) begin
               entry_in = ctrl.head;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

FILE: rtl/sorted_key_table.sv
// Top level of the sorted key table: control sequencer and the cell chain.
// Uses skt_pkg, skt_cell and sorted_key_table_assert.svh.
`default_nettype none

// Sorted key table: up to CAPACITY entries of a signed key and a payload word,
// kept in ascending key order in a chain of cells.
// Input: raise start with a word on req_data; it is taken at an edge where busy
// is low. Operations: insert, lookup, delete, dump.
// Output: each result word sits on rsp_data for one cycle with rsp_valid high;
// the receiver cannot stall, so every word must be taken as it appears.
// Insert, lookup, delete and dump of an empty table: the accepted word is
// registered, and the execute state forms one result word that is registered
// onto rsp_data; busy is high in the execute state, so no new word is taken
// while one executes. All cells compare and shift in parallel in that state.
// Dump of N entries: one result per cycle, N results in all, each formed in
// the dump state that follows the execute state and registered onto rsp_data;
// busy stays high through both states. The chain rotates one place per word and is back in order after the last.
// Reset: synchronous, active high; busy is high while it is held and the table
// is empty afterwards.
module sorted_key_table #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire skt_pkg::req_type  req_data,
   output logic                   rsp_valid,
   output skt_pkg::rsp_type       rsp_data
);
   import skt_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type            state_ff, state_in;
   req_type              req_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     dump_ff, dump_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   cell_ctrl_type        cell_ctrl;
   entry_type            cell_q [CAPACITY];
   logic [CAPACITY-1:0]  lt_vec;
   logic [CAPACITY-1:0]  eq_vec;
   logic [CAPACITY-1:0]  occ;
   logic [CAPACITY-1:0]  ins_oh;

   logic                 accept;
   logic                 found;
   logic                 full;
   logic                 dump_last;
   logic [IDX_W-1:0]     found_idx;
   logic [IDX_W-1:0]     ins_idx;
   entry_type            found_entry;

   assign busy      = reset || (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign dump_last = ((CNT_W'(dump_ff) + CNT_W'(1)) == count_ff);

   // ---------------- cell chain ----------------
   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         assign occ[g] = (count_ff > CNT_W'(g));
         if (g == 0) begin : g_first
            assign ins_oh[g] = !lt_vec[g];
         end else begin : g_rest
            assign ins_oh[g] = !lt_vec[g] && lt_vec[g-1];
         end
         skt_cell u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl),
            .occ_self    (occ[g]),
            .occ_next    ((g == CAPACITY - 1) ? 1'b0 : occ[(g + 1) % CAPACITY]),
            .left_lt     ((g == 0) ? 1'b1 : lt_vec[(g + CAPACITY - 1) % CAPACITY]),
            .left_entry  ((g == 0) ? cell_ctrl.req : cell_q[(g + CAPACITY - 1) % CAPACITY]),
            .right_entry ((g == CAPACITY - 1) ? cell_q[g] : cell_q[(g + 1) % CAPACITY]),
            .entry       (cell_q[g]),
            .lt          (lt_vec[g]),
            .eq          (eq_vec[g])
         );
      end
   endgenerate

   // Encode the match and the insertion point; keys are unique so at most one eq bit is set.
   always_comb begin
      found_idx   = '0;
      ins_idx     = '0;
      found_entry = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (eq_vec[i]) begin
            found_idx   = found_idx | IDX_W'(i);
            found_entry = found_entry | cell_q[i];
         end
         if (ins_oh[i]) begin
            ins_idx = ins_idx | IDX_W'(i);
         end
      end
   end
   assign found = |eq_vec;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if ((req_ff.operation == OP_DUMP) && (count_ff != '0)) begin
               state_in = ST_DUMP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (dump_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- outputs and chain control ----------------
   always_comb begin
      cell_ctrl.cmd   = CMD_HOLD;
      cell_ctrl.req   = '{key: req_ff.key, value: req_ff.value};
      cell_ctrl.head  = cell_q[0];
      count_in        = count_ff;
      dump_in         = dump_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = '0;
      rsp_in.last     = 1'b1;
      case (state_ff)
         ST_EXEC: begin
            dump_in = '0;
            case (req_ff.operation)
               OP_INSERT: begin
                  rsp_valid_in = 1'b1;
                  if (full) begin
                     rsp_in.status = STATUS_FULL;
                  end else if (found) begin
                     rsp_in.status    = STATUS_DUP;
                     rsp_in.index     = INDEX_W'(found_idx);
                     rsp_in.key_out   = found_entry.key;
                     rsp_in.value_out = found_entry.value;
                  end else begin
                     cell_ctrl.cmd    = CMD_INSERT;
                     count_in         = count_ff + CNT_W'(1);
                     rsp_in.status    = STATUS_OK;
                     rsp_in.index     = INDEX_W'(ins_idx);
                     rsp_in.key_out   = req_ff.key;
                     rsp_in.value_out = req_ff.value;
                  end
               end
               OP_LOOKUP, OP_DELETE: begin
                  rsp_valid_in = 1'b1;
                  if (found) begin
                     rsp_in.status    = STATUS_OK;
                     rsp_in.index     = INDEX_W'(found_idx);
                     rsp_in.key_out   = found_entry.key;
                     rsp_in.value_out = found_entry.value;
                     if (req_ff.operation == OP_DELETE) begin
                        cell_ctrl.cmd = CMD_DELETE;
                        count_in      = count_ff - CNT_W'(1);
                     end
                  end else begin
                     rsp_in.status = STATUS_MISSING;
                  end
               end
               OP_DUMP: begin
                  // non-empty dump streams from the head in the next state
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = STATUS_EMPTY;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b0;
               end
            endcase
            rsp_in.entry_count = COUNT_W'(count_in);
         end
         ST_DUMP: begin
            cell_ctrl.cmd      = CMD_ROTATE;
            dump_in            = dump_ff + IDX_W'(1);
            rsp_valid_in       = 1'b1;
            rsp_in.status      = STATUS_OK;
            rsp_in.index       = INDEX_W'(dump_ff);
            rsp_in.key_out     = cell_q[0].key;
            rsp_in.value_out   = cell_q[0].value;
            rsp_in.entry_count = COUNT_W'(count_ff);
            rsp_in.last        = dump_last;
         end
         default: begin
            cell_ctrl.cmd = CMD_HOLD;
         end
      endcase
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_ff      <= dump_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   // ---------------- assertions ----------------
`include "sorted_key_table_assert.svh"

   `SKT_ASSERT(a_count_bound, (count_ff <= CNT_W'(CAPACITY)), "entry count above capacity")
   `SKT_ASSERT(a_unique_match, $onehot0(eq_vec), "more than one cell matches the key")
   `SKT_ASSERT(a_accept_busy, (accept |=> busy), "accepted word did not raise busy")
   `SKT_ASSERT_IMPL(a_insert_point, ((state_ff == ST_EXEC) && !full), $onehot(ins_oh), "no single insertion point")

endmodule

`default_nettype wire
